>>> hw/rtl/frrm_pkg.sv
// Package for the firewall rule range matcher.
// Holds request, response, command and table entry types and width constants.
// No dependencies.
package frrm_pkg;

  localparam int RULES_DEFAULT = 64;
  localparam int SLOT_W        = 6;
  localparam int PORT_W        = 16;
  localparam int ADDR_W        = 32;
  localparam int QUEUE_DEPTH   = 2;

  typedef struct packed {
    logic              req_type;
    logic [SLOT_W-1:0] slot;
    logic              inbound;
    logic              udp;
    logic [PORT_W-1:0] port_low;
    logic [PORT_W-1:0] port_high;
    logic [ADDR_W-1:0] addr_low;
    logic [ADDR_W-1:0] addr_high;
    logic [PORT_W-1:0] pkt_port;
    logic [ADDR_W-1:0] pkt_addr;
  } req_t;

  typedef struct packed {
    logic is_query;
    logic accepted;
  } rsp_t;

  // Classified request as it travels through the queue
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_ACK,
    CMD_QUERY
  } cmd_e;

  typedef struct packed {
    cmd_e              kind;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        dir_proto;
    logic [PORT_W-1:0] port_low;
    logic [PORT_W-1:0] port_high;
    logic [ADDR_W-1:0] addr_low;
    logic [ADDR_W-1:0] addr_high;
    logic [PORT_W-1:0] pkt_port;
    logic [ADDR_W-1:0] pkt_addr;
  } cmd_t;

  // One rule table word
  typedef struct packed {
    logic              valid;
    logic [1:0]        dir_proto;
    logic [PORT_W-1:0] port_high;
    logic [PORT_W-1:0] port_low;
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
  } rule_t;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_IDLE,
    BK_SCAN,
    BK_FIN
  } back_state_e;

endpackage

>>> hw/rtl/frrm_if.sv
// Request and response channel interfaces for the rule range matcher.
// Depends on frrm_pkg.
interface frrm_req_if;
  import frrm_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface frrm_rsp_if;
  import frrm_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/frrm_front.sv
// Front end: accepts requests and classifies them into queue commands.
// Depends on frrm_pkg and frrm_if.
module frrm_front #(
  parameter int RULES = frrm_pkg::RULES_DEFAULT
) (
  frrm_req_if.sink     req_i,
  input  logic         init_done_i,
  output logic         cmd_valid_o,
  input  logic         cmd_ready_i,
  output frrm_pkg::cmd_t cmd_o
);
  import frrm_pkg::*;

  logic in_table;

  // hold off requests while the table is being cleared
  assign req_i.ready = init_done_i & cmd_ready_i;
  assign cmd_valid_o = req_i.valid & init_done_i;

  assign in_table = (32'(req_i.payload.slot) < RULES);

  always_comb begin
    cmd_o.slot      = req_i.payload.slot;
    cmd_o.dir_proto = {req_i.payload.inbound, req_i.payload.udp};
    cmd_o.port_low  = req_i.payload.port_low;
    cmd_o.port_high = req_i.payload.port_high;
    cmd_o.addr_low  = req_i.payload.addr_low;
    cmd_o.addr_high = req_i.payload.addr_high;
    cmd_o.pkt_port  = req_i.payload.pkt_port;
    cmd_o.pkt_addr  = req_i.payload.pkt_addr;
    // a load beyond the table only gets its acknowledge
    if (req_i.payload.req_type) begin
      cmd_o.kind = CMD_QUERY;
    end else if (in_table) begin
      cmd_o.kind = CMD_LOAD;
    end else begin
      cmd_o.kind = CMD_ACK;
    end
  end

endmodule

>>> hw/rtl/frrm_queue.sv
// Short command queue between the front end and the back end.
// Depends on frrm_pkg.
module frrm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  frrm_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output frrm_pkg::cmd_t pop_data_o
);
  import frrm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/frrm_back.sv
// Back end: owns the rule table memory, executes loads and scans queries.
// Depends on frrm_pkg and frrm_if.
module frrm_back #(
  parameter int RULES = frrm_pkg::RULES_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  frrm_pkg::cmd_t cmd_i,
  output logic           init_done_o,
  frrm_rsp_if.source     rsp_o
);
  import frrm_pkg::*;

  localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RULES - 1);

  rule_t             table_mem [RULES];
  rule_t             rd_data_q;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  logic [IDX_W-1:0]  wr_addr;
  rule_t             wr_data;

  back_state_e       state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic              hit_q, hit_d;
  logic [1:0]        dp_q;
  logic [PORT_W-1:0] port_q;
  logic [ADDR_W-1:0] addr_q;
  logic              pkt_load;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q;
  rsp_t              out_data;
  logic              out_load;
  logic              out_free;
  logic              match;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign init_done_o = (state_q != BK_INIT);

  // range test on the rule read last cycle; inverted ranges fail by themselves
  assign match = rd_data_q.valid && (rd_data_q.dir_proto == dp_q) &&
                 (port_q >= rd_data_q.port_low) && (port_q <= rd_data_q.port_high) &&
                 (addr_q >= rd_data_q.addr_low) && (addr_q <= rd_data_q.addr_high);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    rd_vld_d    = 1'b0;
    hit_d       = hit_q | (rd_vld_q & match);
    cmd_ready_o = 1'b0;
    we          = 1'b0;
    wr_addr     = idx_q;
    wr_data     = '0;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    pkt_load    = 1'b0;
    out_load    = 1'b0;
    out_data    = '0;
    unique case (state_q)
      BK_INIT: begin
        we = 1'b1;
        if (idx_q == IDX_LAST) begin
          idx_d   = '0;
          state_d = BK_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          case (cmd_i.kind)
            CMD_LOAD: begin
              we                = 1'b1;
              wr_addr           = IDX_W'(cmd_i.slot);
              wr_data.valid     = 1'b1;
              wr_data.dir_proto = cmd_i.dir_proto;
              wr_data.port_low  = cmd_i.port_low;
              wr_data.port_high = cmd_i.port_high;
              wr_data.addr_low  = cmd_i.addr_low;
              wr_data.addr_high = cmd_i.addr_high;
              out_load          = 1'b1;
            end
            CMD_QUERY: begin
              pkt_load = 1'b1;
              hit_d    = 1'b0;
              idx_d    = '0;
              state_d  = BK_SCAN;
            end
            default: begin
              // out-of-table load: acknowledge only
              out_load = 1'b1;
            end
          endcase
        end
      end
      BK_SCAN: begin
        rd_en    = 1'b1;
        rd_vld_d = 1'b1;
        if (idx_q == IDX_LAST) begin
          idx_d   = '0;
          state_d = BK_FIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      BK_FIN: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_data.is_query = 1'b1;
          out_data.accepted = hit_d;
          state_d           = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_INIT;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rd_vld_q    <= rd_vld_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_load) begin
      dp_q   <= cmd_i.dir_proto;
      port_q <= cmd_i.pkt_port;
      addr_q <= cmd_i.pkt_addr;
    end
    if (out_load) begin
      out_q <= out_data;
    end
  end

  // rule table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= table_mem[rd_addr];
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

endmodule

>>> hw/rtl/firewall_rule_range_matcher.sv
// Top level of the firewall rule range matcher.
// Depends on frrm_pkg, frrm_if, frrm_front, frrm_queue and frrm_back.
//
//   channel   dir   modport   carries
//   req_i     in    sink      load rule / query packet request
//   rsp_o     out   source    load acknowledge / query answer
//
// Operation: a load is written to the table and acknowledged through the response
//   register once the back end takes it from the queue. A query scans the table
//   one rule a cycle through the single read port of the rule table memory.
// Reset: a clearing pass writes every table entry invalid, with req_i.ready held
//   low throughout.
// Stalls: a two-entry queue parts the front end from the back end and a
//   response register parts the back end from rsp_o, so requests are still
//   taken while an answer waits to be collected.
module firewall_rule_range_matcher #(
  parameter int RULES = frrm_pkg::RULES_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  frrm_req_if.sink   req_i,
  frrm_rsp_if.source rsp_o
);
  import frrm_pkg::*;

  // front end to queue
  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  // queue to back end
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;
  // table clearing finished
  logic init_done;

  // classify each request and hand it to the queue
  frrm_front #(
    .RULES (RULES)
  ) u_front (
    .req_i       (req_i),
    .init_done_i (init_done),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready),
    .cmd_o       (push_data)
  );

  // decouple acceptance from execution
  frrm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // execute loads and scan the table for queries
  frrm_back #(
    .RULES (RULES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_data),
    .init_done_o (init_done),
    .rsp_o       (rsp_o)
  );

endmodule
